@@ rtl/lgs_pkg.sv @@
// Shared constants, types and codes for the Gauss-Seidel Laplace solver.
package lgs_pkg;

	localparam int MAX_SIDE   = 64;
	localparam int MAX_SWEEPS = 65535;

	localparam int SIDE_W = $clog2(MAX_SIDE);
	localparam int CNT_W  = SIDE_W + 1;
	localparam int ADDR_W = 2 * SIDE_W;
	localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
	localparam int SWP_W  = $clog2(MAX_SWEEPS + 1);

	localparam int TEMP_W  = 32;
	localparam int SUM_W   = 48;
	localparam int TOL_W   = 47;
	localparam int COUNT_W = 17;
	localparam int CFG_W   = 47;
	localparam int IDX_W   = 3;

	localparam logic [SUM_W-1:0]   START_CHANGE = SUM_W'(999) << 16;
	localparam logic [SUM_W-1:0]   SUM_MAX      = '1;
	localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;
	localparam logic [15:0]        HALF_WEIGHT  = 16'd32768;

	localparam logic [IDX_W-1:0] REG_COLS   = 3'd0;
	localparam logic [IDX_W-1:0] REG_ROWS   = 3'd1;
	localparam logic [IDX_W-1:0] REG_LEFT   = 3'd2;
	localparam logic [IDX_W-1:0] REG_RIGHT  = 3'd3;
	localparam logic [IDX_W-1:0] REG_BOTTOM = 3'd4;
	localparam logic [IDX_W-1:0] REG_TOP    = 3'd5;
	localparam logic [IDX_W-1:0] REG_WEIGHT = 3'd6;
	localparam logic [IDX_W-1:0] REG_TOL    = 3'd7;

	localparam logic OP_SOLVE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_LIMIT  = 2'd1;
	localparam logic [1:0] ST_REJECT = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FILL,
		S_CHECK,
		S_RW,
		S_RE,
		S_RS,
		S_RN,
		S_RC,
		S_MX,
		S_MY,
		S_RND,
		S_ACC,
		S_RESP
	} state_t;

endpackage

@@ rtl/laplace_gauss_seidel_solver.sv @@
// Top level: Gauss-Seidel solver for the 2D Laplace equation on a grid memory.
//
// Channels: item_* takes solve (op 0) or point-read (op 1) items; result_*
// returns one beat per item with temperature, sweep_count and status. Both
// use valid/stall: a beat moves on a clock edge with valid high, stall low.
// cfg_* writes the eight setup registers (valid/ready, always ready); write
// them only while the block is idle.
// The grid sits in one memory of MAX_SIDE*MAX_SIDE words with a registered
// read. A solve first fills the whole grid, one word per cycle, then sweeps
// the interior. Each interior point goes through these steps in order: five
// single-port reads (west, east, south, north, old), an x and a y multiply,
// round/saturate, and write-back with change accumulation. A read goes from
// idle to the response state, which loads the result register once that
// register is free; the block is back in idle, ready for the next item, as
// the beat goes valid.
// One item is in the block at a time; item_stall is high while it works.
// If result_stall is high the result register holds and the block waits.
// Reset sets the setup and control registers to defaults and marks no solve
// done; the grid memory needs no clearing since reads reach only solved points.
module laplace_gauss_seidel_solver
	import lgs_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [IDX_W-1:0]         cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	input  logic                     item_valid,
	output logic                     item_stall,
	input  logic                     op,
	input  logic [5:0]               col_index,
	input  logic [5:0]               row_index,
	output logic                     result_valid,
	input  logic                     result_stall,
	output logic signed [TEMP_W-1:0] temperature,
	output logic [COUNT_W-1:0]       sweep_count,
	output logic [1:0]               status
);

	// setup registers
	logic [6:0]               grid_cols_q, grid_rows_q;
	logic signed [TEMP_W-1:0] left_q, right_q, bottom_q, top_q;
	logic [15:0]              weight_q;
	logic [TOL_W-1:0]         tol_q;

	// solver state
	state_t                   state_q, state_d;
	logic [CNT_W-1:0]         nx_q, ny_q, solved_cols_q, solved_rows_q;
	logic [SIDE_W-1:0]        i_q, j_q;
	logic [15:0]              wx_q, wy_q;
	logic [SUM_W-1:0]         change_q, sum_q;
	logic [SWP_W-1:0]         sweeps_q;
	logic                     solved_q, converged_q;
	logic signed [TEMP_W-1:0] west_q, east_q, south_q, north_q, old_q, nv_q;
	logic signed [50:0]       px_q, py_q;
	logic                     resp_read_q, resp_ok_q;
	logic signed [TEMP_W-1:0] rdata_q;

	// memory port
	logic [TEMP_W-1:0]        mem [DEPTH];
	logic                     re, we;
	logic [ADDR_W-1:0]        raddr, waddr;
	logic [TEMP_W-1:0]        wdata;

	// derived values
	logic                     accept, out_free, fill_last, sweep_go;
	logic                     last_j, last_i;
	logic [CNT_W-1:0]         nx_cl, ny_cl;
	logic signed [TEMP_W-1:0] fill_val;
	logic signed [32:0]       xs, ys, diff, adiff;
	logic signed [50:0]       rsum, rshift;
	logic signed [TEMP_W-1:0] nv_sat;
	logic [SUM_W:0]           sum_ext;
	logic [31:0]              count_ext;
	logic                     read_ok;

	assign cfg_ready  = 1'b1;
	assign accept     = item_valid && !item_stall;
	assign out_free   = !result_valid || !result_stall;

	always_comb begin
		if (grid_cols_q < 7'd3) begin
			nx_cl = CNT_W'(3);
		end else if (32'(grid_cols_q) > MAX_SIDE) begin
			nx_cl = CNT_W'(MAX_SIDE);
		end else begin
			nx_cl = CNT_W'(grid_cols_q);
		end
		if (grid_rows_q < 7'd3) begin
			ny_cl = CNT_W'(3);
		end else if (32'(grid_rows_q) > MAX_SIDE) begin
			ny_cl = CNT_W'(MAX_SIDE);
		end else begin
			ny_cl = CNT_W'(grid_rows_q);
		end
	end

	assign fill_last = (CNT_W'(i_q) == nx_q - 1'b1) && (CNT_W'(j_q) == ny_q - 1'b1);
	assign sweep_go  = (change_q > SUM_W'(tol_q)) && (32'(sweeps_q) < MAX_SWEEPS);
	assign last_j    = (CNT_W'(j_q) + 2'd2 >= ny_q);
	assign last_i    = (CNT_W'(i_q) + 2'd2 >= nx_q);
	assign read_ok   = solved_q && (32'(col_index) < 32'(solved_cols_q))
		&& (32'(row_index) < 32'(solved_rows_q));

	always_comb begin
		if (i_q == '0) begin
			fill_val = left_q;
		end else if (CNT_W'(i_q) == nx_q - 1'b1) begin
			fill_val = right_q;
		end else if (j_q == '0) begin
			fill_val = bottom_q;
		end else if (CNT_W'(j_q) == ny_q - 1'b1) begin
			fill_val = top_q;
		end else begin
			fill_val = '0;
		end
	end

	// datapath arithmetic
	assign xs      = {west_q[31], west_q} + {east_q[31], east_q};
	assign ys      = {south_q[31], south_q} + {north_q[31], north_q};
	assign rsum    = px_q + py_q + 51'sd32768;
	assign rshift  = rsum >>> 16;
	always_comb begin
		if (rshift > 51'sd2147483647) begin
			nv_sat = 32'sh7fffffff;
		end else if (rshift < -51'sd2147483648) begin
			nv_sat = 32'sh80000000;
		end else begin
			nv_sat = rshift[31:0];
		end
	end
	assign diff    = {nv_q[31], nv_q} - {old_q[31], old_q};
	assign adiff   = diff[32] ? -diff : diff;
	assign sum_ext = {1'b0, sum_q} + (SUM_W + 1)'(adiff[31:0]) + (SUM_W + 1)'({adiff[32], 32'd0});
	assign count_ext = 32'(sweeps_q) + 32'd1;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = (op == OP_SOLVE) ? S_FILL : S_RESP;
				end
			end
			S_FILL:  state_d = fill_last ? S_CHECK : S_FILL;
			S_CHECK: state_d = sweep_go ? S_RW : S_RESP;
			S_RW:    state_d = S_RE;
			S_RE:    state_d = S_RS;
			S_RS:    state_d = S_RN;
			S_RN:    state_d = S_RC;
			S_RC:    state_d = S_MX;
			S_MX:    state_d = S_MY;
			S_MY:    state_d = S_RND;
			S_RND:   state_d = S_ACC;
			S_ACC:   state_d = (last_j && last_i) ? S_CHECK : S_RW;
			S_RESP:  state_d = out_free ? S_IDLE : S_RESP;
			default: state_d = S_IDLE;
		endcase
	end

	// memory control
	always_comb begin
		re         = 1'b0;
		we         = 1'b0;
		raddr      = {i_q, j_q};
		waddr      = {i_q, j_q};
		wdata      = nv_q;
		item_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				item_stall = 1'b0;
				re         = accept;
				raddr      = {SIDE_W'(col_index), SIDE_W'(row_index)};
			end
			S_FILL: begin
				we    = 1'b1;
				wdata = fill_val;
			end
			S_RW: begin
				re    = 1'b1;
				raddr = {i_q - 1'b1, j_q};
			end
			S_RE: begin
				re    = 1'b1;
				raddr = {i_q + 1'b1, j_q};
			end
			S_RS: begin
				re    = 1'b1;
				raddr = {i_q, j_q - 1'b1};
			end
			S_RN: begin
				re    = 1'b1;
				raddr = {i_q, j_q + 1'b1};
			end
			S_RC:    re = 1'b1;
			S_ACC:   we = 1'b1;
			default: re = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	// setup register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_cols_q <= 7'd64;
			grid_rows_q <= 7'd64;
			left_q      <= '0;
			right_q     <= '0;
			bottom_q    <= '0;
			top_q       <= '0;
			weight_q    <= 16'd16384;
			tol_q       <= TOL_W'(65536);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_COLS:   grid_cols_q <= cfg_data[6:0];
				REG_ROWS:   grid_rows_q <= cfg_data[6:0];
				REG_LEFT:   left_q      <= cfg_data[31:0];
				REG_RIGHT:  right_q     <= cfg_data[31:0];
				REG_BOTTOM: bottom_q    <= cfg_data[31:0];
				REG_TOP:    top_q       <= cfg_data[31:0];
				REG_WEIGHT: weight_q    <= cfg_data[15:0];
				REG_TOL:    tol_q       <= cfg_data[TOL_W-1:0];
				default:    tol_q       <= tol_q;
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			i_q           <= '0;
			j_q           <= '0;
			change_q      <= '0;
			sum_q         <= '0;
			sweeps_q      <= '0;
			solved_q      <= 1'b0;
			converged_q   <= 1'b0;
			solved_cols_q <= '0;
			solved_rows_q <= '0;
			nx_q          <= '0;
			ny_q          <= '0;
			resp_read_q   <= 1'b0;
			resp_ok_q     <= 1'b0;
			result_valid  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_RESP && out_free) begin
				result_valid <= 1'b1;
			end else if (result_valid && !result_stall) begin
				result_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						resp_read_q <= (op == OP_READ);
						resp_ok_q   <= read_ok;
						nx_q        <= nx_cl;
						ny_q        <= ny_cl;
						i_q         <= '0;
						j_q         <= '0;
					end
				end
				S_FILL: begin
					if (CNT_W'(j_q) == ny_q - 1'b1) begin
						j_q <= '0;
						i_q <= i_q + 1'b1;
					end else begin
						j_q <= j_q + 1'b1;
					end
					if (fill_last) begin
						change_q <= START_CHANGE;
						sweeps_q <= '0;
					end
				end
				S_CHECK: begin
					i_q   <= SIDE_W'(1);
					j_q   <= SIDE_W'(1);
					sum_q <= '0;
					if (!sweep_go) begin
						converged_q   <= !(change_q > SUM_W'(tol_q));
						solved_q      <= 1'b1;
						solved_cols_q <= nx_q;
						solved_rows_q <= ny_q;
					end
				end
				S_ACC: begin
					sum_q <= sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
					if (last_j) begin
						j_q <= SIDE_W'(1);
						i_q <= i_q + 1'b1;
					end else begin
						j_q <= j_q + 1'b1;
					end
					if (last_j && last_i) begin
						change_q <= sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
						sweeps_q <= sweeps_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// point datapath and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_CHECK: begin
				wx_q <= (weight_q > HALF_WEIGHT) ? HALF_WEIGHT : weight_q;
				wy_q <= HALF_WEIGHT - ((weight_q > HALF_WEIGHT) ? HALF_WEIGHT : weight_q);
			end
			S_RE:  west_q  <= rdata_q;
			S_RS:  east_q  <= rdata_q;
			S_RN:  south_q <= rdata_q;
			S_RC:  north_q <= rdata_q;
			S_MX: begin
				old_q <= rdata_q;
				px_q  <= 51'($signed({1'b0, wx_q}) * xs);
			end
			S_MY:  py_q <= 51'($signed({1'b0, wy_q}) * ys);
			S_RND: nv_q <= nv_sat;
			S_RESP: begin
				if (out_free) begin
					if (!solved_q) begin
						sweep_count <= '0;
					end else if (count_ext > 32'(COUNT_MAX)) begin
						sweep_count <= COUNT_MAX;
					end else begin
						sweep_count <= COUNT_W'(count_ext);
					end
					if (resp_read_q) begin
						temperature <= resp_ok_q ? rdata_q : '0;
						status      <= resp_ok_q ? ST_OK : ST_REJECT;
					end else begin
						temperature <= '0;
						status      <= converged_q ? ST_OK : ST_LIMIT;
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

@@ rtl/lgs_checker.sv @@
// Port-level checker for the solver, bound to the top level.
module lgs_checker
	import lgs_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     item_valid,
	input logic                     item_stall,
	input logic                     op,
	input logic                     result_valid,
	input logic                     result_stall,
	input logic signed [TEMP_W-1:0] temperature,
	input logic [COUNT_W-1:0]       sweep_count,
	input logic [1:0]               status
);

	// one item at a time: stall rises right after a beat is taken
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("item taken while another is in flight");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(temperature)
			&& $stable(status))
		else $error("stalled result beat changed");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> status == ST_OK || status == ST_LIMIT || status == ST_REJECT)
		else $error("bad status code");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == ST_REJECT |-> temperature == '0)
		else $error("rejected read carries data");

	a_limit_count: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == ST_LIMIT |-> sweep_count != '0)
		else $error("unconverged solve with no sweeps");

endmodule

bind laplace_gauss_seidel_solver lgs_checker u_lgs_checker (.*);

@@ tb/laplace_gauss_seidel_solver_test.sv @@
// Self-checking testbench for the Gauss-Seidel Laplace solver: solves, point reads, register sweeps.
module laplace_gauss_seidel_solver_test;
	import lgs_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [TEMP_W-1:0] temp;
		logic [COUNT_W-1:0]       count;
		logic [1:0]               stat;
	} point_beat_t;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [IDX_W-1:0]         cfg_index;
	logic [CFG_W-1:0]         cfg_data;
	logic                     item_valid;
	logic                     item_stall;
	logic                     op;
	logic [5:0]               col_index;
	logic [5:0]               row_index;
	logic                     result_valid;
	logic                     result_stall;
	logic signed [TEMP_W-1:0] temperature;
	logic [COUNT_W-1:0]       sweep_count;
	logic [1:0]               status;

	laplace_gauss_seidel_solver i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.item_valid(item_valid), .item_stall(item_stall),
		.op(op), .col_index(col_index), .row_index(row_index),
		.result_valid(result_valid), .result_stall(result_stall),
		.temperature(temperature), .sweep_count(sweep_count), .status(status)
	);

	// predictor state
	int           heat_grid [DEPTH];
	int           cols_reg, rows_reg, left_reg, right_reg, bottom_reg, top_reg;
	int           weight_reg;
	longint       tol_reg;
	longint       sweeps_run;
	bit           have_solve, converged;
	int           solved_cols, solved_rows;

	point_beat_t  pending_beats [$];
	int           mismatches;
	bit           gaps_on;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("== FAIL ==");
		$finish;
	end

	always @(posedge clk) begin
		result_stall <= gaps_on && ($urandom_range(99) < 25);
	end

	always @(posedge clk) begin
		point_beat_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_beats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat t=%h n=%0d s=%0d",
						temperature, sweep_count, status);
			end else begin
				want = pending_beats.pop_front();
				if (temperature !== want.temp || sweep_count !== want.count ||
						status !== want.stat) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp t=%h n=%0d s=%0d, got t=%h n=%0d s=%0d",
							want.temp, want.count, want.stat,
							temperature, sweep_count, status);
				end
			end
		end
	end

	function automatic int clamp_side(int v);
		if (v < 3) return 3;
		if (v > MAX_SIDE) return MAX_SIDE;
		return v;
	endfunction

	function automatic int round_sat(longint s);
		longint r;
		r = (s + 64'sd32768) >>> 16;
		if (r > 64'sd2147483647) return 32'h7fffffff;
		if (r < -64'sd2147483648) return 32'h80000000;
		return int'(r);
	endfunction

	function automatic void solve_grid();
		int     nx, ny, v, nv;
		longint wx, wy, chg, sum, d;
		nx = clamp_side(cols_reg);
		ny = clamp_side(rows_reg);
		wx = (weight_reg > 32768) ? 32768 : weight_reg;
		wy = 32768 - wx;
		for (int i = 0; i < nx; i++)
			for (int j = 0; j < ny; j++) begin
				if (i == 0) v = left_reg;
				else if (i == nx - 1) v = right_reg;
				else if (j == 0) v = bottom_reg;
				else if (j == ny - 1) v = top_reg;
				else v = 0;
				heat_grid[i*MAX_SIDE + j] = v;
			end
		chg = longint'(999) << 16;
		sweeps_run = 0;
		while (chg > tol_reg && sweeps_run < MAX_SWEEPS) begin
			sum = 0;
			for (int i = 1; i + 1 < nx; i++)
				for (int j = 1; j + 1 < ny; j++) begin
					nv = round_sat(wx * (longint'(heat_grid[(i-1)*MAX_SIDE + j]) +
						longint'(heat_grid[(i+1)*MAX_SIDE + j])) +
						wy * (longint'(heat_grid[i*MAX_SIDE + j - 1]) +
						longint'(heat_grid[i*MAX_SIDE + j + 1])));
					d = longint'(nv) - longint'(heat_grid[i*MAX_SIDE + j]);
					heat_grid[i*MAX_SIDE + j] = nv;
					sum += (d < 0) ? -d : d;
					if (sum > longint'(SUM_MAX)) sum = longint'(SUM_MAX);
				end
			chg = sum;
			sweeps_run++;
		end
		converged = !(chg > tol_reg);
		have_solve = 1'b1;
		solved_cols = nx;
		solved_rows = ny;
	endfunction

	function automatic point_beat_t predict_item(bit rd, int c, int r);
		point_beat_t b;
		longint n;
		if (!rd) solve_grid();
		n = have_solve ? sweeps_run + 1 : 0;
		b.count = (n > longint'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(n);
		if (!rd) begin
			b.temp = '0;
			b.stat = converged ? ST_OK : ST_LIMIT;
		end else if (!have_solve || c >= solved_cols || r >= solved_rows) begin
			b.temp = '0;
			b.stat = ST_REJECT;
		end else begin
			b.temp = heat_grid[c*MAX_SIDE + r];
			b.stat = ST_OK;
		end
		return b;
	endfunction

	task automatic send_item(logic o, logic [5:0] c, logic [5:0] r);
		if (gaps_on && $urandom_range(99) < 25) begin
			item_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 40);
		end
		item_valid <= 1'b1;
		op <= o;
		col_index <= c;
		row_index <= r;
		do @(posedge clk); while (item_stall);
		pending_beats.push_back(predict_item(o == OP_READ, c, r));
	endtask

	task automatic drain();
		@(posedge clk);
		item_valid <= 1'b0;
		while (pending_beats.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_COLS:   cols_reg = int'(val[6:0]);
			REG_ROWS:   rows_reg = int'(val[6:0]);
			REG_LEFT:   left_reg = val[31:0];
			REG_RIGHT:  right_reg = val[31:0];
			REG_BOTTOM: bottom_reg = val[31:0];
			REG_TOP:    top_reg = val[31:0];
			REG_WEIGHT: weight_reg = int'(val[15:0]);
			default:    tol_reg = longint'(val[46:0]);
		endcase
	endtask

	// temperatures carry junk in the unused upper bits
	task automatic set_temps(int l, int r, int b, int t);
		write_reg(REG_LEFT, {15'($urandom), l});
		write_reg(REG_RIGHT, {15'($urandom), r});
		write_reg(REG_BOTTOM, {15'($urandom), b});
		write_reg(REG_TOP, {15'($urandom), t});
	endtask

	task automatic test_read_before_solve();
		send_item(OP_READ, 6'd0, 6'd0);
		send_item(OP_READ, 6'd63, 6'd63);
		drain();
	endtask

	task automatic test_full_grid();
		// reset registers: 64x64, zero edges, one sweep
		send_item(OP_SOLVE, 6'($urandom), 6'($urandom));
		send_item(OP_READ, 6'd63, 6'd63);
		send_item(OP_READ, 6'd0, 6'd0);
		send_item(OP_READ, 6'd31, 6'd47);
		drain();
	endtask

	task automatic test_clamp();
		write_reg(REG_COLS, 47'd0);
		write_reg(REG_ROWS, 47'd127);
		send_item(OP_SOLVE, 6'd0, 6'd0);
		send_item(OP_READ, 6'd2, 6'd63);
		send_item(OP_READ, 6'd3, 6'd0);
		drain();
		write_reg(REG_COLS, 47'd65);
		write_reg(REG_ROWS, 47'd2);
		send_item(OP_SOLVE, 6'd0, 6'd0);
		send_item(OP_READ, 6'd63, 6'd2);
		send_item(OP_READ, 6'd10, 6'd3);
		drain();
	endtask

	task automatic test_weight_extremes();
		write_reg(REG_COLS, 47'd3);
		write_reg(REG_ROWS, 47'd3);
		write_reg(REG_TOL, 47'd0);
		set_temps(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000);
		write_reg(REG_WEIGHT, 47'd65535);
		send_item(OP_SOLVE, 6'd0, 6'd0);
		send_item(OP_READ, 6'd1, 6'd1);
		send_item(OP_READ, 6'd0, 6'd2);
		send_item(OP_READ, 6'd2, 6'd0);
		drain();
		write_reg(REG_WEIGHT, 47'd0);
		send_item(OP_SOLVE, 6'd0, 6'd0);
		send_item(OP_READ, 6'd1, 6'd1);
		drain();
		write_reg(REG_WEIGHT, 47'd32768);
		set_temps(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
		send_item(OP_SOLVE, 6'd0, 6'd0);
		send_item(OP_READ, 6'd1, 6'd1);
		drain();
	endtask

	task automatic test_loose_tolerance();
		// bound above the start change: no sweep at all
		write_reg(REG_COLS, 47'd5);
		write_reg(REG_ROWS, 47'd4);
		write_reg(REG_TOL, '1);
		send_item(OP_SOLVE, 6'd0, 6'd0);
		send_item(OP_READ, 6'd2, 6'd2);
		send_item(OP_READ, 6'd4, 6'd3);
		send_item(OP_READ, 6'd4, 6'd4);
		drain();
	endtask

	task automatic test_random();
		int tol_bits;
		for (int ph = 0; ph < 10; ph++) begin
			gaps_on = (ph < 3 || ph > 5);
			write_reg(REG_COLS, 47'($urandom_range(3, 7)));
			write_reg(REG_ROWS, 47'($urandom_range(3, 7)));
			set_temps($urandom, $urandom, $urandom, $urandom);
			if ($urandom_range(3) == 0)
				write_reg(REG_WEIGHT, 47'($urandom_range(65535)));
			else
				write_reg(REG_WEIGHT, 47'($urandom_range(32768)));
			tol_bits = $urandom_range(16, 40);
			write_reg(REG_TOL, (47'd1 << tol_bits) | 47'($urandom_range(65535)));
			send_item(OP_SOLVE, 6'($urandom), 6'($urandom));
			for (int k = 0; k < 11; k++) begin
				if ($urandom_range(99) < 8)
					send_item(OP_SOLVE, 6'($urandom), 6'($urandom));
				else if ($urandom_range(99) < 80)
					send_item(OP_READ, 6'($urandom_range(solved_cols - 1)),
						6'($urandom_range(solved_rows - 1)));
				else
					send_item(OP_READ, 6'($urandom), 6'($urandom));
			end
			drain();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		item_valid = 1'b0;
		op = OP_SOLVE;
		col_index = '0;
		row_index = '0;
		result_stall = 1'b0;
		gaps_on = 1'b1;
		mismatches = 0;
		cols_reg = 64; rows_reg = 64;
		left_reg = 0; right_reg = 0; bottom_reg = 0; top_reg = 0;
		weight_reg = 16384;
		tol_reg = 65536;
		sweeps_run = 0;
		have_solve = 1'b0;
		converged = 1'b0;
		solved_cols = 0;
		solved_rows = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_read_before_solve();
		test_full_grid();
		test_clamp();
		test_weight_extremes();
		test_loose_tolerance();
		test_random();

		if (mismatches == 0 && pending_beats.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/lgs_pkg.sv
rtl/laplace_gauss_seidel_solver.sv
rtl/lgs_checker.sv
tb/laplace_gauss_seidel_solver_test.sv
